// ----- hdl/elfbid_pkg.sv -----
// types, constants and helpers shared by the build-id note extractor
package elfbid_pkg;

   localparam int unsigned HDR_BYTES = 12;
   localparam logic [31:0] BUILD_ID_TYPE = 32'd3;
   localparam logic [7:0] GNU_CHARS [3] = '{8'h47, 8'h4e, 8'h55};

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_NAME,
      PH_SKIP,
      PH_DESC,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_BYTE = 2'd0,
      ST_LAST = 2'd1,
      ST_NONE = 2'd2,
      ST_BAD  = 2'd3
   } status_type;

   typedef enum logic {
      CSR_SECTION_LENGTH = 1'b0,
      CSR_BIG_ENDIAN     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [31:0] section_length;
      logic        big_endian;
   } cfg_type;

   typedef struct packed {
      logic       first_byte;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [6:0] hex_low;
      logic [6:0] hex_high;
      logic [7:0] id_byte;
   } rsp_type;

   // lowercase ascii hex digit of one nibble
   function automatic logic [6:0] hex_digit(input logic [3:0] nib);
      logic [6:0] res;
      if (nib < 4'd10) begin
         res = 7'h30 + {3'b000, nib};
      end else begin
         res = 7'h57 + {3'b000, nib};
      end
      return res;
   endfunction

endpackage

// ----- hdl/elf_note_build_id_extractor.sv -----
// top level of the elf note build-id extractor
//
// channel  direction  transaction carries
// req_*    in         tdata: data_byte; tuser: first_byte
// rsp_*    out        tdata: id_byte, hex_high, hex_low; tuser: status
// csr_*    in         register index and write data
//
// one byte per cycle while rsp is not stalled: input register, header/name/descriptor
// logic, result register. a result reaches rsp through both of those registers.
// synchronous reset; the parse starts at offset 0 afterwards.
// a stalled rsp holds the result while one more byte waits in the input
// register; only then does req_tready drop. csr writes are always taken.
module elf_note_build_id_extractor
   import elfbid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] id_byte, [14:8] hex_high, [21:15] hex_low
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   logic [31:0] len_ff;
   logic        big_ff;
   cfg_type     cfg;
   req_type     req_item, held_item;
   logic        held_valid, advance, space;
   logic        res_valid;
   rsp_type     res, out_item;

   assign csr_ready          = 1'b1;
   assign cfg.section_length = len_ff;
   assign cfg.big_endian     = big_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= 32'd1;
         big_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SECTION_LENGTH: len_ff <= csr_data;
            CSR_BIG_ENDIAN:     big_ff <= csr_data[0];
            default:            len_ff <= len_ff;
         endcase
      end
   end

   assign req_item.data_byte  = req_tdata;
   assign req_item.first_byte = req_tuser[0];
   assign advance             = held_valid && space;

   elfbid_input_reg u_input (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .advance    (advance),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   elfbid_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .advance   (advance),
      .item      (held_item),
      .res_valid (res_valid),
      .res       (res)
   );

   elfbid_output_reg u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (res_valid),
      .load_item (res),
      .space     (space),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (out_item)
   );

   assign rsp_tdata = {2'b00, out_item.hex_low, out_item.hex_high, out_item.id_byte};
   assign rsp_tuser = out_item.status;

endmodule

// ----- hdl/elfbid_input_reg.sv -----
// input register stage for the byte stream
module elfbid_input_reg
   import elfbid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   input  logic    advance,
   output logic    held_valid,
   output req_type held_item
);

   logic    valid_ff, valid_in;
   req_type item_ff;
   logic    take;

   assign in_ready   = !valid_ff || advance;
   assign take       = in_valid && in_ready;
   assign valid_in   = take || (valid_ff && !advance);
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= in_item;
      end
   end

endmodule

// ----- hdl/elfbid_parser.sv -----
// note walker: parse state and the per-byte update
module elfbid_parser
   import elfbid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    advance,
   input  req_type item,
   output logic    res_valid,
   output rsp_type res
);

   phase_type   phase_ff, phase_in;
   logic [32:0] offset_ff, offset_in;
   logic [32:0] remain_ff, remain_in;
   logic [31:0] words_ff [3];
   logic [31:0] words_in [3];
   logic [3:0]  wshift_ff, wshift_in;
   logic        match_ff, match_in;
   logic [2:0]  nidx_ff, nidx_in;

   phase_type   phase_e;
   logic [32:0] offset_e, offset_inc, len33;
   logic [3:0]  wshift_e;
   logic [32:0] left_cur, left_inc;
   logic [31:0] namesz, descsz;
   logic [32:0] name_pad4, desc_pad4, remain_dec;
   logic [33:0] desc_end;
   logic [1:0]  widx;
   logic [31:0] word_cur, word_new;
   logic [1:0]  name_gap;
   logic        match_now, is_gnu;
   logic [7:0]  b;

   always_comb begin
      b          = item.data_byte;
      phase_e    = item.first_byte ? PH_HEADER : phase_ff;
      offset_e   = item.first_byte ? 33'd0 : offset_ff;
      wshift_e   = item.first_byte ? 4'd0 : wshift_ff;
      len33      = {1'b0, cfg.section_length};
      offset_inc = offset_e + 33'd1;
      left_cur   = (offset_e >= len33) ? 33'd0 : len33 - offset_e;
      left_inc   = (offset_inc >= len33) ? 33'd0 : len33 - offset_inc;
      namesz     = words_ff[0];
      descsz     = words_ff[1];
      name_pad4  = ({1'b0, namesz} + 33'd3) & ~33'd3;
      desc_pad4  = ({1'b0, descsz} + 33'd3) & ~33'd3;
      desc_end   = {1'b0, offset_inc} + {1'b0, desc_pad4};
      remain_dec = (remain_ff != 33'd0) ? remain_ff - 33'd1 : 33'd0;
      name_gap   = 2'd0 - namesz[1:0];
      widx       = wshift_e[3:2];

      unique case (widx)
         2'd0:    word_cur = words_ff[0];
         2'd1:    word_cur = words_ff[1];
         2'd2:    word_cur = words_ff[2];
         default: word_cur = 32'd0;
      endcase
      // the first byte of each word starts from zero
      if (wshift_e[1:0] == 2'd0) begin
         word_cur = 32'd0;
      end
      if (cfg.big_endian) begin
         word_new = {word_cur[23:0], b};
      end else begin
         unique case (wshift_e[1:0])
            2'd0:    word_new = word_cur | {24'd0, b};
            2'd1:    word_new = word_cur | {16'd0, b, 8'd0};
            2'd2:    word_new = word_cur | {8'd0, b, 16'd0};
            default: word_new = word_cur | {b, 24'd0};
         endcase
      end

      // name compare against "GNU" with an optional trailing zero
      match_now = match_ff;
      if (remain_ff > {31'd0, name_gap}) begin
         if (nidx_ff < 3'd3 && b != GNU_CHARS[nidx_ff[1:0]]) begin
            match_now = 1'b0;
         end else if (nidx_ff == 3'd3 && b != 8'd0) begin
            match_now = 1'b0;
         end
      end
      is_gnu = match_now && (namesz == 32'd3 || namesz == 32'd4) &&
               (words_ff[2] == BUILD_ID_TYPE);

      phase_in    = phase_e;
      offset_in   = offset_e;
      remain_in   = remain_ff;
      words_in    = words_ff;
      wshift_in   = wshift_e;
      match_in    = match_ff;
      nidx_in     = nidx_ff;
      res_valid   = 1'b0;
      res.status  = ST_NONE;
      res.id_byte = 8'd0;
      res.hex_high = 7'd0;
      res.hex_low  = 7'd0;

      unique case (phase_e)
         PH_HEADER: begin
            if (wshift_e == 4'd0 && offset_e >= len33) begin
               res_valid  = 1'b1;
               res.status = ST_NONE;
               phase_in   = PH_DONE;
            end else if (wshift_e == 4'd0 && left_cur < 33'(HDR_BYTES)) begin
               res_valid  = 1'b1;
               res.status = ST_BAD;
               phase_in   = PH_DONE;
            end else begin
               words_in[widx] = word_new;
               offset_in      = offset_inc;
               wshift_in      = wshift_e + 4'd1;
               if (wshift_e == 4'(HDR_BYTES - 1)) begin
                  wshift_in = 4'd0;
                  if ({1'b0, namesz} > left_inc) begin
                     res_valid  = 1'b1;
                     res.status = ST_BAD;
                     phase_in   = PH_DONE;
                  end else if (namesz == 32'd0) begin
                     if ({1'b0, descsz} > left_inc) begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD;
                        phase_in   = PH_DONE;
                     end else if (desc_end >= {2'b00, cfg.section_length}) begin
                        res_valid  = 1'b1;
                        res.status = ST_NONE;
                        phase_in   = PH_DONE;
                     end else begin
                        remain_in = desc_pad4;
                        phase_in  = (desc_pad4 == 33'd0) ? PH_HEADER : PH_SKIP;
                     end
                  end else if (name_pad4 > left_inc) begin
                     res_valid  = 1'b1;
                     res.status = ST_BAD;
                     phase_in   = PH_DONE;
                  end else begin
                     remain_in = name_pad4;
                     match_in  = 1'b1;
                     nidx_in   = 3'd0;
                     phase_in  = PH_NAME;
                  end
               end
            end
         end
         PH_NAME: begin
            match_in  = match_now;
            nidx_in   = (nidx_ff == 3'd4) ? nidx_ff : nidx_ff + 3'd1;
            remain_in = remain_ff - 33'd1;
            offset_in = offset_inc;
            if (remain_ff == 33'd1) begin
               if (!is_gnu) begin
                  if ({1'b0, descsz} > left_inc) begin
                     res_valid  = 1'b1;
                     res.status = ST_BAD;
                     phase_in   = PH_DONE;
                  end else if (desc_end >= {2'b00, cfg.section_length}) begin
                     res_valid  = 1'b1;
                     res.status = ST_NONE;
                     phase_in   = PH_DONE;
                  end else begin
                     remain_in = desc_pad4;
                     phase_in  = (desc_pad4 == 33'd0) ? PH_HEADER : PH_SKIP;
                  end
               end else if (descsz == 32'd0 || {1'b0, descsz} > left_inc) begin
                  res_valid  = 1'b1;
                  res.status = ST_BAD;
                  phase_in   = PH_DONE;
               end else begin
                  remain_in = {1'b0, descsz};
                  phase_in  = PH_DESC;
               end
            end
         end
         PH_SKIP: begin
            offset_in = offset_inc;
            remain_in = remain_dec;
            if (remain_dec == 33'd0) begin
               phase_in = PH_HEADER;
            end
         end
         PH_DESC: begin
            offset_in    = offset_inc;
            remain_in    = remain_dec;
            res_valid    = 1'b1;
            res.status   = ST_BYTE;
            res.id_byte  = b;
            res.hex_high = hex_digit(b[7:4]);
            res.hex_low  = hex_digit(b[3:0]);
            if (remain_dec == 33'd0) begin
               res.status = ST_LAST;
               phase_in   = PH_DONE;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      res_valid = res_valid && advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         offset_ff <= 33'd0;
         remain_ff <= 33'd0;
         words_ff  <= '{32'd0, 32'd0, 32'd0};
         wshift_ff <= 4'd0;
         match_ff  <= 1'b1;
         nidx_ff   <= 3'd0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         remain_ff <= remain_in;
         words_ff  <= words_in;
         wshift_ff <= wshift_in;
         match_ff  <= match_in;
         nidx_ff   <= nidx_in;
      end
   end

endmodule

// ----- hdl/elfbid_output_reg.sv -----
// result register toward the response stream
module elfbid_output_reg
   import elfbid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  rsp_type load_item,
   output logic    space,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_item
);

   logic    valid_ff, valid_in;
   rsp_type item_ff;

   assign space     = !valid_ff || out_ready;
   assign valid_in  = load || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= load_item;
      end
   end

endmodule
